// File: hw/rtl/csvfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvfs_pkg
// Shared types, sizes and character codes for the CSV field splitter.
// ----------------------------------------------------------------------------
package csvfs_pkg;

    // Row and field capacity
    localparam int MAX_COLUMNS     = 64;
    localparam int MAX_FIELD_BYTES = 256;

    // Internal counter widths
    localparam int CIDX_W = $clog2(MAX_COLUMNS);
    localparam int FLEN_W = $clog2(MAX_FIELD_BYTES + 1);
    localparam int CNT_W  = CIDX_W + 1;

    // Result field widths
    localparam int COLUMN_W   = 6;
    localparam int POSITION_W = 8;
    localparam int CHAR_W     = 8;
    localparam int COUNT_W    = 7;
    localparam int ERR_W      = 2;
    localparam int KIND_W     = 2;
    localparam int TDATA_W    = 32;

    // Saturation limits of the result fields
    localparam int COLUMN_MAX   = 63;
    localparam int POSITION_MAX = 255;
    localparam int COUNT_MAX    = 127;

    // Character codes
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] DELIM_RESET = 8'h2C;

    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE  = 2'd0,
        KIND_FIELD = 2'd1,
        KIND_ROW   = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE        = 2'd0,
        ERR_QUOTED_LF   = 2'd1,
        ERR_TOO_MANY    = 2'd2,
        ERR_UNUSED      = 2'd3
    } err_t;

    typedef struct packed {
        kind_t                   kind;
        logic [COLUMN_W-1:0]     column;
        logic [POSITION_W-1:0]   position;
        logic [CHAR_W-1:0]       char_out;
        logic [COUNT_W-1:0]      field_count;
        logic                    truncated;
        err_t                    error_code;
    } res_t;

    function automatic logic [COLUMN_W-1:0] sat_column(input logic [CIDX_W-1:0] v);
        logic [CIDX_W+COLUMN_W-1:0] w;
        w = (CIDX_W + COLUMN_W)'(v);
        if (w > (CIDX_W + COLUMN_W)'(COLUMN_MAX)) begin
            return COLUMN_W'(COLUMN_MAX);
        end
        return w[COLUMN_W-1:0];
    endfunction

    function automatic logic [POSITION_W-1:0] sat_position(input logic [FLEN_W-1:0] v);
        logic [FLEN_W+POSITION_W-1:0] w;
        w = (FLEN_W + POSITION_W)'(v);
        if (w > (FLEN_W + POSITION_W)'(POSITION_MAX)) begin
            return POSITION_W'(POSITION_MAX);
        end
        return w[POSITION_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] sat_count(input logic [CNT_W-1:0] v);
        logic [CNT_W+COUNT_W-1:0] w;
        w = (CNT_W + COUNT_W)'(v);
        if (w > (CNT_W + COUNT_W)'(COUNT_MAX)) begin
            return COUNT_W'(COUNT_MAX);
        end
        return w[COUNT_W-1:0];
    endfunction

endpackage

// File: hw/rtl/csvfs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvfs_core
// Row state registers and the per-byte classification that produces at most
// one result for each accepted byte.
// ----------------------------------------------------------------------------
module csvfs_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [7:0]           byte_in,
    input  logic                 end_of_input,
    input  logic [7:0]           delimiter,
    output logic                 res_valid,
    output csvfs_pkg::res_t      res
);

    logic                          in_quote_reg, in_quote_next;
    logic                          in_text_reg, in_text_next;
    logic                          overflowed_reg, overflowed_next;
    logic [csvfs_pkg::CIDX_W-1:0]  column_index_reg, column_index_next;
    logic [csvfs_pkg::FLEN_W-1:0]  field_length_reg, field_length_next;

    logic [csvfs_pkg::CNT_W-1:0]   count_now;
    logic                          last_column;
    logic                          room_left;
    csvfs_pkg::res_t               base;

    assign count_now   = csvfs_pkg::CNT_W'(column_index_reg) + csvfs_pkg::CNT_W'(1);
    assign last_column = count_now >= csvfs_pkg::CNT_W'(csvfs_pkg::MAX_COLUMNS);
    assign room_left   = field_length_reg < csvfs_pkg::FLEN_W'(csvfs_pkg::MAX_FIELD_BYTES);

    always_comb begin
        base.kind        = csvfs_pkg::KIND_BYTE;
        base.column      = csvfs_pkg::sat_column(column_index_reg);
        base.position    = csvfs_pkg::sat_position(field_length_reg);
        base.char_out    = '0;
        base.field_count = '0;
        base.truncated   = 1'b0;
        base.error_code  = csvfs_pkg::ERR_NONE;
    end

    always_comb begin
        in_quote_next     = in_quote_reg;
        in_text_next      = in_text_reg;
        overflowed_next   = overflowed_reg;
        column_index_next = column_index_reg;
        field_length_next = field_length_reg;
        res_valid         = 1'b0;
        res               = base;

        if (end_of_input) begin
            res_valid       = 1'b1;
            res.kind        = csvfs_pkg::KIND_ROW;
            res.field_count = csvfs_pkg::sat_count(count_now);
            res.truncated   = overflowed_reg;
        end else if (byte_in == csvfs_pkg::CHAR_QUOTE) begin
            in_quote_next = !in_quote_reg;
            in_text_next  = !in_quote_reg;
        end else if (byte_in == csvfs_pkg::CHAR_CR) begin
            // drop
        end else if (byte_in == csvfs_pkg::CHAR_LF) begin
            res_valid = 1'b1;
            if (in_quote_reg) begin
                res.kind       = csvfs_pkg::KIND_ERROR;
                res.error_code = csvfs_pkg::ERR_QUOTED_LF;
            end else begin
                res.kind        = csvfs_pkg::KIND_ROW;
                res.field_count = csvfs_pkg::sat_count(count_now);
                res.truncated   = overflowed_reg;
            end
        end else if (byte_in == delimiter && !in_quote_reg) begin
            res_valid = 1'b1;
            if (last_column) begin
                res.kind       = csvfs_pkg::KIND_ERROR;
                res.error_code = csvfs_pkg::ERR_TOO_MANY;
            end else begin
                res.kind          = csvfs_pkg::KIND_FIELD;
                res.truncated     = overflowed_reg;
                column_index_next = count_now[csvfs_pkg::CIDX_W-1:0];
                field_length_next = '0;
                in_text_next      = 1'b0;
                overflowed_next   = 1'b0;
            end
        end else if (in_text_reg || byte_in != csvfs_pkg::CHAR_SPACE) begin
            in_text_next = 1'b1;
            if (room_left) begin
                res_valid         = 1'b1;
                res.char_out      = byte_in;
                field_length_next = field_length_reg + csvfs_pkg::FLEN_W'(1);
            end else begin
                overflowed_next = 1'b1;
            end
        end

        // Any row end or error returns the row state to reset
        if (res_valid && (res.kind == csvfs_pkg::KIND_ROW ||
                          res.kind == csvfs_pkg::KIND_ERROR)) begin
            in_quote_next     = 1'b0;
            in_text_next      = 1'b0;
            overflowed_next   = 1'b0;
            column_index_next = '0;
            field_length_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_quote_reg     <= 1'b0;
            in_text_reg      <= 1'b0;
            overflowed_reg   <= 1'b0;
            column_index_reg <= '0;
            field_length_reg <= '0;
        end else if (step) begin
            in_quote_reg     <= in_quote_next;
            in_text_reg      <= in_text_next;
            overflowed_reg   <= overflowed_next;
            column_index_reg <= column_index_next;
            field_length_reg <= field_length_next;
        end
    end

endmodule

// File: hw/rtl/csvfs_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvfs_out_stage
// Result register with a skid entry, so the input ready is a register output.
// ----------------------------------------------------------------------------
module csvfs_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  csvfs_pkg::res_t      in_res,
    output logic                 out_valid,
    input  logic                 out_ready,
    output csvfs_pkg::res_t      out_res
);

    logic              main_valid_reg;
    logic              skid_valid_reg;
    csvfs_pkg::res_t   main_reg;
    csvfs_pkg::res_t   skid_reg;
    logic              in_fire;
    logic              main_free;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign main_free = !main_valid_reg || out_ready;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (main_free) begin
            // advance the held beat first; no new beat arrives while it is held
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= in_fire;
            end
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (main_free) begin
            main_reg <= skid_valid_reg ? skid_reg : in_res;
        end
        if (!main_free && in_fire) begin
            skid_reg <= in_res;
        end
    end

endmodule

// File: hw/rtl/csv_field_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_field_splitter
// CSV tokenizer: places each incoming byte in its column and field position.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one raw byte per beat in s_tdata; s_tlast marks end of input,
//   in which case the byte is ignored and the current row is closed.
//   m_ channel: zero or one result per input beat; m_tuser carries the
//   result kind (byte stored, field ended, row ended, error), m_tdata the
//   column, position, byte, field count, truncation flag and error code.
//   cfg_ channel: writes the delimiter byte (reset value is a comma); write
//   it only while the block is idle. cfg_ready is always high.
// Timing: one byte per cycle sustained while m_tready is high. Each result is
//   registered before it shows on m_. The input ready comes from the skid entry
//   of the result register, so a stalled receiver blocks input once it fills.
// Reset: aresetn low clears the row state, empties the result register and
//   restores the delimiter. Stalls never lose or repeat a beat.
// ----------------------------------------------------------------------------
module csv_field_splitter (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata: byte_in[7:0]
    input  logic [7:0]   s_tdata,
    input  logic         s_tlast,
    input  logic         s_tvalid,
    output logic         s_tready,
    // m_tdata: column[5:0], position[13:6], char_out[21:14],
    //          field_count[28:22], truncated[29], error_code[31:30]
    output logic [csvfs_pkg::TDATA_W-1:0] m_tdata,
    // m_tuser: kind[1:0]
    output logic [1:0]   m_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic [7:0]   cfg_data,
    input  logic         cfg_valid,
    output logic         cfg_ready
);

    logic [7:0]        delimiter_reg;
    logic              step;
    logic              res_valid;
    logic              res_ready;
    csvfs_pkg::res_t   res;
    csvfs_pkg::res_t   out_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delimiter_reg <= csvfs_pkg::DELIM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            delimiter_reg <= cfg_data;
        end
    end

    assign s_tready = res_ready;
    assign step     = s_tvalid && s_tready;

    csvfs_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .byte_in      (s_tdata),
        .end_of_input (s_tlast),
        .delimiter    (delimiter_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    csvfs_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (step && res_valid),
        .in_ready  (res_ready),
        .in_res    (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tuser = out_res.kind;
    assign m_tdata = {out_res.error_code, out_res.truncated, out_res.field_count,
                      out_res.char_out, out_res.position, out_res.column};

    // Assertions
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_skid_implies_main: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("skid entry full while result register empty");

    a_byte_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == csvfs_pkg::KIND_BYTE) |->
        (m_tdata[31:30] == csvfs_pkg::ERR_NONE && m_tdata[28:22] == 7'd0))
        else $error("stored byte carries error code or field count");

    a_error_coded: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == csvfs_pkg::KIND_ERROR) |->
        (m_tdata[31:30] == csvfs_pkg::ERR_QUOTED_LF ||
         m_tdata[31:30] == csvfs_pkg::ERR_TOO_MANY))
        else $error("error result without a valid error code");

endmodule

// File: sim/csv_field_splitter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_field_splitter_tb
// Self-checking bench for the CSV field splitter. A short stimulus table covers
// the corner characters, then generated rows (quoted fields, stray quotes,
// carriage returns, over-long fields, over-wide rows and raw noise) run under
// several delimiters and idle mixes. Each result beat is checked field by field
// against an in-bench tokenizer that tracks quote, text, column and length.
// ----------------------------------------------------------------------------
module csv_field_splitter_tb;

    localparam int CLK_HALF       = 5;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT    = 4000;
    localparam int PHASE_ITEMS    = 12;
    localparam int NUM_PHASES     = 6;
    localparam int NUM_DIRECTED   = 26;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [7:0]      data_byte;
        logic            eoi;
        logic            typed;
        csvfs_pkg::res_t res;
    } step_t;

    localparam csvfs_pkg::res_t NO_TOKEN = '{csvfs_pkg::KIND_BYTE, 6'd0, 8'd0, 8'd0, 7'd0,
                                             1'b0, csvfs_pkg::ERR_NONE};

    // Typed results are those that follow at a glance from reset, the byte
    // extremes and the error cases; every other row goes to the tokenizer.
    localparam step_t DIRECTED [NUM_DIRECTED] = '{
        '{8'hFF, 1'b1, 1'b1, '{csvfs_pkg::KIND_ROW,   6'd0, 8'd0, 8'h00, 7'd1, 1'b0,
                               csvfs_pkg::ERR_NONE}},
        '{8'h00, 1'b0, 1'b1, '{csvfs_pkg::KIND_BYTE,  6'd0, 8'd0, 8'h00, 7'd0, 1'b0,
                               csvfs_pkg::ERR_NONE}},
        '{8'hFF, 1'b0, 1'b1, '{csvfs_pkg::KIND_BYTE,  6'd0, 8'd1, 8'hFF, 7'd0, 1'b0,
                               csvfs_pkg::ERR_NONE}},
        '{8'h2C, 1'b0, 1'b1, '{csvfs_pkg::KIND_FIELD, 6'd0, 8'd2, 8'h00, 7'd0, 1'b0,
                               csvfs_pkg::ERR_NONE}},
        '{8'h20, 1'b0, 1'b0, NO_TOKEN},
        '{8'h20, 1'b0, 1'b0, NO_TOKEN},
        '{8'h61, 1'b0, 1'b0, NO_TOKEN},
        '{8'h20, 1'b0, 1'b0, NO_TOKEN},
        '{8'h0D, 1'b0, 1'b0, NO_TOKEN},
        '{8'h0A, 1'b0, 1'b1, '{csvfs_pkg::KIND_ROW,   6'd1, 8'd2, 8'h00, 7'd2, 1'b0,
                               csvfs_pkg::ERR_NONE}},
        '{8'h22, 1'b0, 1'b0, NO_TOKEN},
        '{8'h2C, 1'b0, 1'b0, NO_TOKEN},
        '{8'h22, 1'b0, 1'b0, NO_TOKEN},
        '{8'h20, 1'b0, 1'b0, NO_TOKEN},
        '{8'h62, 1'b0, 1'b0, NO_TOKEN},
        '{8'h22, 1'b0, 1'b0, NO_TOKEN},
        '{8'h0A, 1'b0, 1'b1, '{csvfs_pkg::KIND_ERROR, 6'd0, 8'd2, 8'h00, 7'd0, 1'b0,
                               csvfs_pkg::ERR_QUOTED_LF}},
        '{8'h22, 1'b0, 1'b0, NO_TOKEN},
        '{8'h71, 1'b0, 1'b0, NO_TOKEN},
        '{8'h0A, 1'b1, 1'b0, NO_TOKEN},
        '{8'h2C, 1'b1, 1'b1, '{csvfs_pkg::KIND_ROW,   6'd0, 8'd0, 8'h00, 7'd1, 1'b0,
                               csvfs_pkg::ERR_NONE}},
        '{8'h80, 1'b0, 1'b0, NO_TOKEN},
        '{8'h7F, 1'b0, 1'b0, NO_TOKEN},
        '{8'h0A, 1'b0, 1'b0, NO_TOKEN},
        '{8'h20, 1'b0, 1'b0, NO_TOKEN},
        '{8'h0A, 1'b0, 1'b1, '{csvfs_pkg::KIND_ROW,   6'd0, 8'd0, 8'h00, 7'd1, 1'b0,
                               csvfs_pkg::ERR_NONE}}
    };

    localparam logic [7:0] PHASE_DELIM [NUM_PHASES] =
        '{8'h00, 8'hFF, csvfs_pkg::CHAR_SPACE, 8'h3B, csvfs_pkg::CHAR_QUOTE,
          csvfs_pkg::DELIM_RESET};
    localparam int PHASE_TX_IDLE [NUM_PHASES] = '{0, 55, 0, 22, 0, 0};
    localparam int PHASE_RX_STALL [NUM_PHASES] = '{0, 0, 55, 22, 22, 0};

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tlast   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  cfg_data  = csvfs_pkg::DELIM_RESET;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;

    // Bench-side sideband, sampled with the beat it travels beside
    logic              typed_valid = 1'b0;
    csvfs_pkg::res_t   typed_res   = NO_TOKEN;

    // Tokenizer state, owned by the checker process
    logic [7:0]  exp_delim     = csvfs_pkg::DELIM_RESET;
    logic        row_in_quote  = 1'b0;
    logic        row_in_text   = 1'b0;
    logic        row_overflow  = 1'b0;
    int          row_column    = 0;
    int          row_length    = 0;

    csvfs_pkg::res_t pending_tokens [$];
    int          fail_count    = 0;
    int          beats_in      = 0;
    int          beats_out     = 0;
    int          items_sent    = 0;
    int          tx_idle_pct   = 0;
    int          rx_stall_pct  = 0;
    logic        rx_hold_req   = 1'b0;

    csv_field_splitter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic csvfs_pkg::res_t make_token(input csvfs_pkg::kind_t k, input int col,
                                                   input int len, input logic [7:0] ch,
                                                   input int cnt, input logic trunc,
                                                   input csvfs_pkg::err_t err);
        csvfs_pkg::res_t t;
        t.kind        = k;
        t.column      = csvfs_pkg::COLUMN_W'(col > csvfs_pkg::COLUMN_MAX ?
                                             csvfs_pkg::COLUMN_MAX : col);
        t.position    = csvfs_pkg::POSITION_W'(len > csvfs_pkg::POSITION_MAX ?
                                               csvfs_pkg::POSITION_MAX : len);
        t.char_out    = ch;
        t.field_count = csvfs_pkg::COUNT_W'(cnt > csvfs_pkg::COUNT_MAX ?
                                            csvfs_pkg::COUNT_MAX : cnt);
        t.truncated   = trunc;
        t.error_code  = err;
        return t;
    endfunction

    function automatic void restart_row();
        row_in_quote = 1'b0;
        row_in_text  = 1'b0;
        row_overflow = 1'b0;
        row_column   = 0;
        row_length   = 0;
    endfunction

    // Advance the tokenizer by one input beat; made is low when no result follows
    function automatic void tokenize_byte(input logic [7:0] b, input logic eoi,
                                          output logic made, output csvfs_pkg::res_t tok);
        made = 1'b1;
        tok  = NO_TOKEN;
        if (eoi) begin
            tok = make_token(csvfs_pkg::KIND_ROW, row_column, row_length, 8'h00,
                             row_column + 1, row_overflow, csvfs_pkg::ERR_NONE);
            restart_row();
        end else if (b == csvfs_pkg::CHAR_QUOTE) begin
            row_in_quote = !row_in_quote;
            row_in_text  = row_in_quote;
            made = 1'b0;
        end else if (b == csvfs_pkg::CHAR_CR) begin
            made = 1'b0;
        end else if (b == csvfs_pkg::CHAR_LF) begin
            if (row_in_quote) begin
                tok = make_token(csvfs_pkg::KIND_ERROR, row_column, row_length, 8'h00, 0,
                                 1'b0, csvfs_pkg::ERR_QUOTED_LF);
            end else begin
                tok = make_token(csvfs_pkg::KIND_ROW, row_column, row_length, 8'h00,
                                 row_column + 1, row_overflow, csvfs_pkg::ERR_NONE);
            end
            restart_row();
        end else if (b == exp_delim && !row_in_quote) begin
            if (row_column + 1 >= csvfs_pkg::MAX_COLUMNS) begin
                tok = make_token(csvfs_pkg::KIND_ERROR, row_column, row_length, 8'h00, 0,
                                 1'b0, csvfs_pkg::ERR_TOO_MANY);
                restart_row();
            end else begin
                tok = make_token(csvfs_pkg::KIND_FIELD, row_column, row_length, 8'h00, 0,
                                 row_overflow, csvfs_pkg::ERR_NONE);
                row_column++;
                row_length   = 0;
                row_in_text  = 1'b0;
                row_overflow = 1'b0;
            end
        end else if (row_in_text || b != csvfs_pkg::CHAR_SPACE) begin
            row_in_text = 1'b1;
            if (row_length < csvfs_pkg::MAX_FIELD_BYTES) begin
                tok = make_token(csvfs_pkg::KIND_BYTE, row_column, row_length, b, 0, 1'b0,
                                 csvfs_pkg::ERR_NONE);
                row_length++;
            end else begin
                // drop the byte, mark the field as cut short
                row_overflow = 1'b1;
                made = 1'b0;
            end
        end else begin
            made = 1'b0;
        end
    endfunction

    // Predict on accepted input first, then check the result beat of this edge
    always @(posedge aclk) begin
        logic made;
        csvfs_pkg::res_t tok;
        csvfs_pkg::res_t got;
        csvfs_pkg::res_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                exp_delim = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                beats_in++;
                tokenize_byte(s_tdata, s_tlast, made, tok);
                if (typed_valid) begin
                    made = 1'b1;
                    tok  = typed_res;
                end
                if (made) begin
                    pending_tokens.push_back(tok);
                end
            end
            if (m_tvalid && m_tready) begin
                beats_out++;
                got.kind        = csvfs_pkg::kind_t'(m_tuser);
                got.column      = m_tdata[5:0];
                got.position    = m_tdata[13:6];
                got.char_out    = m_tdata[21:14];
                got.field_count = m_tdata[28:22];
                got.truncated   = m_tdata[29];
                got.error_code  = csvfs_pkg::err_t'(m_tdata[31:30]);
                if (pending_tokens.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("%0t: result with none pending: kind %0d data %h",
                                 $time, m_tuser, m_tdata);
                    end
                end else begin
                    want = pending_tokens.pop_front();
                    if (got.kind != want.kind || got.column != want.column ||
                        got.position != want.position || got.char_out != want.char_out ||
                        got.field_count != want.field_count ||
                        got.truncated != want.truncated ||
                        got.error_code != want.error_code) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("%0t: mismatch kind/col/pos/char/count/trunc/err", $time);
                            $display("    expected %0d %0d %0d %h %0d %0d %0d",
                                     want.kind, want.column, want.position, want.char_out,
                                     want.field_count, want.truncated, want.error_code);
                            $display("    actual   %0d %0d %0d %h %0d %0d %0d",
                                     got.kind, got.column, got.position, got.char_out,
                                     got.field_count, got.truncated, got.error_code);
                        end
                    end
                end
            end
        end
    end

    // Receiver: random stalls, or one long hold when asked
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog: end the run after a long stretch with no beat on any channel
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT) break;
        end
        $display("%0t: no beat for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, pending_tokens.size());
        $display("FAILED: results differ");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic eoi,
                             input logic typed = 1'b0, input csvfs_pkg::res_t tr = NO_TOKEN);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata     <= b;
        s_tlast     <= eoi;
        typed_valid <= typed;
        typed_res   <= tr;
        s_tvalid    <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_tokens.size() != 0) @(posedge aclk);
        // allow for beats still in flight that give no result
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_delimiter(input logic [7:0] d);
        wait_for_results();
        cfg_data  <= d;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 8'h61 + 8'($urandom_range(25));
        if (r < 65) return csvfs_pkg::CHAR_SPACE;
        if (r < 70) return csvfs_pkg::CHAR_QUOTE;
        if (r < 74) return csvfs_pkg::CHAR_CR;
        if (r < 77) return csvfs_pkg::CHAR_LF;
        if (r < 80) return exp_delim;
        return 8'($urandom);
    endfunction

    task automatic send_random_field(input int max_len);
        logic quoted;
        quoted = ($urandom_range(3) == 0);
        if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 2)) send_byte(csvfs_pkg::CHAR_SPACE, 1'b0);
        end
        if (quoted) send_byte(csvfs_pkg::CHAR_QUOTE, 1'b0);
        repeat ($urandom_range(0, max_len)) send_byte(pick_byte(), 1'b0);
        // leave the odd quote open so that it runs into the next field
        if (quoted && $urandom_range(9) != 0) send_byte(csvfs_pkg::CHAR_QUOTE, 1'b0);
    endtask

    task automatic send_random_row();
        int mode;
        int n_fields;
        int r;
        mode = $urandom_range(99);
        if (mode < 8) begin
            repeat ($urandom_range(1, 12)) send_byte(8'($urandom), $urandom_range(15) == 0);
        end else begin
            n_fields = $urandom_range(1, 6);
            for (int f = 0; f < n_fields; f++) begin
                if (f != 0) send_byte(exp_delim, 1'b0);
                send_random_field(4);
            end
            r = $urandom_range(19);
            if (r < 3) begin
                send_byte(8'($urandom), 1'b1);
            end else if (r < 19) begin
                if (r < 8) send_byte(csvfs_pkg::CHAR_CR, 1'b0);
                send_byte(csvfs_pkg::CHAR_LF, 1'b0);
            end
        end
    endtask

    // Over-long field opening the widest row, then one column too many;
    // expects a letter-free delimiter
    task automatic send_capacity_rows();
        repeat (csvfs_pkg::MAX_FIELD_BYTES + 2) begin
            send_byte(8'h61 + 8'($urandom_range(25)), 1'b0);
        end
        repeat (csvfs_pkg::MAX_COLUMNS - 1) send_byte(exp_delim, 1'b0);
        send_byte(8'h63, 1'b0);
        send_byte(csvfs_pkg::CHAR_LF, 1'b0);
        repeat (csvfs_pkg::MAX_COLUMNS) send_byte(exp_delim, 1'b0);
        send_byte(csvfs_pkg::CHAR_LF, 1'b0);
    endtask

    initial begin
        int start;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_byte(DIRECTED[i].data_byte, DIRECTED[i].eoi, DIRECTED[i].typed,
                      DIRECTED[i].res);
        end
        send_capacity_rows();

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_delimiter(PHASE_DELIM[p]);
            tx_idle_pct  = PHASE_TX_IDLE[p];
            rx_stall_pct = PHASE_RX_STALL[p];
            start = items_sent;
            if (p == NUM_PHASES - 1) begin
                // hold the receiver off while bytes keep coming, to fill the block
                rx_hold_req = 1'b1;
                repeat (40) send_byte(pick_byte(), 1'b0);
            end
            while (items_sent - start < PHASE_ITEMS / 2) send_random_row();
            wait_for_results();
            while (items_sent - start < PHASE_ITEMS) send_random_row();
        end

        wait_for_results();
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        $display("Covered %0d input beats and %0d result beats over %0d delimiters,",
                 beats_in, beats_out, NUM_PHASES);
        $display("with idle mixes none/sender/receiver/both and one long receiver hold.");
        if (fail_count == 0 && pending_tokens.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
